// ===== src/wpsc_pkg.sv =====
package wpsc_pkg;

	localparam int WINDOW_DEPTH = 32;
	localparam int ADDR_W       = $clog2(WINDOW_DEPTH);
	localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
	localparam int LEN_W        = 6;
	localparam int VALUE_W      = 64;
	localparam int STATUS_W     = 2;
	localparam int MIN_LEN      = 2;
	localparam int RESET_LEN    = 25;
	localparam int QUEUE_DEPTH  = 2;
	localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [STATUS_W-1:0] {
		ST_PREAMBLE = 2'd0,
		ST_VALID    = 2'd1,
		ST_INVALID  = 2'd2
	} status_t;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               check;
		logic [CNT_W-1:0]   len;
	} job_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_RDA,
		BK_SCAN,
		BK_DONE
	} back_state_t;

endpackage

// ===== src/window_pair_sum_checker.sv =====
// Checks each 64-bit value of a stream against the last window_len values (2 to 32, reset 25):
// status is preamble until that many values have been seen, then valid when two distinct earlier
// window values, the older one below the new value, add (mod 2^64) to it, else invalid. Every
// value then enters the window. Values are pushed into a two-entry queue and results are popped
// from a one-entry result register, so either side may stall on its own. A preamble value
// skips the scan; a checked value is scanned pair by pair, ending early when a pair is found
// and skipping the rest of an older value's pairs when it is not below the new value, using the
// single 64-bit adder and comparator walking the window memory's two read ports one pair per cycle.
// window_len is written through cfg_valid/cfg_ready and should only change while no value is in
// flight; stored values are kept across a change.
module window_pair_sum_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [wpsc_pkg::VALUE_W-1:0]  value,
	output logic                          empty,
	input  logic                          pop,
	output logic [wpsc_pkg::STATUS_W-1:0] status,
	output logic [wpsc_pkg::VALUE_W-1:0]  checked_value,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [wpsc_pkg::LEN_W-1:0]    window_len
);
	import wpsc_pkg::*;

	logic q_wr;
	logic q_rd;
	logic q_empty;
	job_t q_wr_job;
	job_t q_rd_job;

	assign cfg_ready = 1'b1;

	wpsc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.value      (value),
		.cfg_valid  (cfg_valid),
		.window_len (window_len),
		.q_full     (full),
		.q_wr       (q_wr),
		.q_job      (q_wr_job)
	);

	wpsc_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (q_wr),
		.wr_data (q_wr_job),
		.rd      (q_rd),
		.full    (full),
		.empty   (q_empty),
		.rd_data (q_rd_job)
	);

	wpsc_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (q_empty),
		.q_job         (q_rd_job),
		.q_rd          (q_rd),
		.pop           (pop),
		.empty         (empty),
		.status        (status),
		.checked_value (checked_value)
	);

endmodule

// ===== src/wpsc_front.sv =====
module wpsc_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	input  logic [wpsc_pkg::VALUE_W-1:0]   value,
	input  logic                           cfg_valid,
	input  logic [wpsc_pkg::LEN_W-1:0]     window_len,
	input  logic                           q_full,
	output logic                           q_wr,
	output wpsc_pkg::job_t                 q_job
);
	import wpsc_pkg::*;

	logic [LEN_W-1:0] len_q;
	logic [CNT_W-1:0] fill_q;
	logic [CNT_W-1:0] eff_len;

	always_comb begin
		if (int'(len_q) < MIN_LEN) begin
			eff_len = CNT_W'(MIN_LEN);
		end else if (int'(len_q) > WINDOW_DEPTH) begin
			eff_len = CNT_W'(WINDOW_DEPTH);
		end else begin
			eff_len = CNT_W'(len_q);
		end
	end

	assign q_wr        = push && !q_full;
	assign q_job.value = value;
	assign q_job.check = (fill_q >= eff_len);
	assign q_job.len   = eff_len;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= LEN_W'(RESET_LEN);
			fill_q <= '0;
		end else begin
			if (cfg_valid) begin
				len_q <= window_len;
			end
			if (q_wr && (int'(fill_q) < WINDOW_DEPTH)) begin
				fill_q <= fill_q + CNT_W'(1);
			end
		end
	end

endmodule

// ===== src/wpsc_queue.sv =====
module wpsc_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr,
	input  wpsc_pkg::job_t wr_data,
	input  logic           rd,
	output logic           full,
	output logic           empty,
	output wpsc_pkg::job_t rd_data
);
	import wpsc_pkg::*;

	job_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_wr;
	logic              do_rd;

	assign full    = (int'(count_q) == QUEUE_DEPTH);
	assign empty   = (count_q == '0);
	assign do_wr   = wr && !full;
	assign do_rd   = rd && !empty;
	assign rd_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (int'(wr_ptr_q) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (int'(rd_ptr_q) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			unique case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== src/wpsc_back.sv =====
module wpsc_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            q_empty,
	input  wpsc_pkg::job_t                  q_job,
	output logic                            q_rd,
	input  logic                            pop,
	output logic                            empty,
	output logic [wpsc_pkg::STATUS_W-1:0]   status,
	output logic [wpsc_pkg::VALUE_W-1:0]    checked_value
);
	import wpsc_pkg::*;

	logic [VALUE_W-1:0] mem [WINDOW_DEPTH];

	back_state_t        state_q;
	back_state_t        state_d;
	logic [VALUE_W-1:0] v_s1;
	logic [CNT_W-1:0]   a_q;
	logic [CNT_W-1:0]   b_q;
	status_t            res_q;
	logic [ADDR_W-1:0]  wp_q;
	logic [VALUE_W-1:0] rd_a_data_q;
	logic [VALUE_W-1:0] rd_b_data_q;
	logic [ADDR_W-1:0]  rd_a_addr;
	logic [ADDR_W-1:0]  rd_b_addr;
	logic               rd_a_en;
	logic               out_load;
	logic               out_valid_q;
	status_t            out_status_q;
	logic [VALUE_W-1:0] out_value_q;
	logic               out_free;
	logic               va_lt;
	logic               hit;
	logic [VALUE_W-1:0] pair_sum;

	assign out_free = !out_valid_q || pop;
	assign pair_sum = rd_a_data_q + rd_b_data_q;
	assign va_lt    = rd_a_data_q < v_s1;
	assign hit      = va_lt && (pair_sum == v_s1);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (!q_empty) begin
					state_d = q_job.check ? BK_RDA : BK_DONE;
				end
			end
			BK_RDA: begin
				state_d = BK_SCAN;
			end
			BK_SCAN: begin
				priority if (hit) begin
					state_d = BK_DONE;
				end else if (va_lt && (b_q > CNT_W'(1))) begin
					state_d = BK_SCAN;
				end else if (a_q > CNT_W'(MIN_LEN)) begin
					state_d = BK_RDA;
				end else begin
					state_d = BK_DONE;
				end
			end
			BK_DONE: begin
				if (out_free) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		q_rd      = 1'b0;
		rd_a_en   = 1'b0;
		out_load  = 1'b0;
		rd_a_addr = wp_q - a_q[ADDR_W-1:0];
		rd_b_addr = wp_q - (b_q[ADDR_W-1:0] - ADDR_W'(1));
		unique case (state_q)
			BK_IDLE: q_rd = !q_empty;
			BK_RDA: begin
				rd_a_en   = 1'b1;
				rd_b_addr = wp_q - (a_q[ADDR_W-1:0] - ADDR_W'(1));
			end
			BK_SCAN: ;
			BK_DONE: out_load = out_free;
			default: ;
		endcase
	end

	// window memory, two registered read ports
	always_ff @(posedge clk) begin
		if (out_load) begin
			mem[wp_q] <= v_s1;
		end
		if (rd_a_en) begin
			rd_a_data_q <= mem[rd_a_addr];
		end
		rd_b_data_q <= mem[rd_b_addr];
	end

	always_ff @(posedge clk) begin
		if (q_rd) begin
			v_s1 <= q_job.value;
			a_q  <= q_job.len;
			res_q <= q_job.check ? ST_INVALID : ST_PREAMBLE;
		end
		if (state_q == BK_RDA) begin
			b_q <= a_q - CNT_W'(1);
		end
		if (state_q == BK_SCAN) begin
			priority if (hit) begin
				res_q <= ST_VALID;
			end else if (va_lt && (b_q > CNT_W'(1))) begin
				b_q <= b_q - CNT_W'(1);
			end else if (a_q > CNT_W'(MIN_LEN)) begin
				a_q <= a_q - CNT_W'(1);
			end
		end
		if (out_load) begin
			out_status_q <= res_q;
			out_value_q  <= v_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			wp_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				wp_q        <= wp_q + ADDR_W'(1);
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign empty         = !out_valid_q;
	assign status        = out_status_q;
	assign checked_value = out_value_q;

endmodule

// ===== src/wpsc_checker.sv =====
module wpsc_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          push,
	input logic                          full,
	input logic                          empty,
	input logic                          pop,
	input logic [wpsc_pkg::STATUS_W-1:0] status,
	input logic [wpsc_pkg::VALUE_W-1:0]  checked_value
);
	import wpsc_pkg::*;

	logic [2:0] in_flight_q;
	logic [1:0] popped_q;
	logic       push_acc;
	logic       pop_acc;

	assign push_acc = push && !full;
	assign pop_acc  = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_flight_q <= '0;
			popped_q    <= '0;
		end else begin
			unique case ({push_acc, pop_acc})
				2'b10:   in_flight_q <= in_flight_q + 3'd1;
				2'b01:   in_flight_q <= in_flight_q - 3'd1;
				default: in_flight_q <= in_flight_q;
			endcase
			if (pop_acc && (popped_q != 2'd2)) begin
				popped_q <= popped_q + 2'd1;
			end
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(status) && $stable(checked_value)))
		else $error("waiting result changed before pop");

	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (status == ST_PREAMBLE || status == ST_VALID || status == ST_INVALID))
		else $error("status code out of range");

	a_first: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && popped_q != 2'd2) |-> (status == ST_PREAMBLE))
		else $error("first transactions after reset not preamble");

	a_none: assert property (@(posedge clk) disable iff (!arst_n)
		(in_flight_q == 3'd0) |-> empty)
		else $error("result shown with no value in flight");

endmodule

bind window_pair_sum_checker wpsc_checker u_wpsc_checker (.*);
